// File: hw/rtl/aes128_block_encrypt_defines.svh
// Assertion helpers for the AES-128 block.
`ifndef AES128_BLOCK_ENCRYPT_DEFINES_SVH
`define AES128_BLOCK_ENCRYPT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define AES_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define AES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define AES_ASSERT(label, clk, rst_n, prop, msg)
`define AES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: hw/rtl/aes_pkg.sv
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned HalfW = 64;

  typedef logic [127:0] blk_t;
  typedef logic [7:0] byte_t;

  typedef enum logic [0:0] {
    RegKeyHigh = 1'b0,
    RegKeyLow  = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic valid;
    logic stall;
  } stage_ctl_t;

  localparam byte_t SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam byte_t RCON [NumRounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // byte i of the state sits at bits 127-8i
  function automatic byte_t get_byte(blk_t b, int unsigned i);
    return b[127-8*i -: 8];
  endfunction

  function automatic byte_t xtime(byte_t x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic blk_t next_key(blk_t k, byte_t rc);
    logic [31:0] t;
    logic [31:0] w [4];
    blk_t r;
    t = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
    w[0] = k[127:96] ^ t;
    w[1] = k[95:64] ^ w[0];
    w[2] = k[63:32] ^ w[1];
    w[3] = k[31:0] ^ w[2];
    r = {w[0], w[1], w[2], w[3]};
    return r;
  endfunction

  function automatic blk_t round_fn(blk_t s, blk_t k, logic last);
    byte_t t [16];
    byte_t a [4];
    blk_t r;
    for (int c = 0; c < 4; c++) begin
      for (int rr = 0; rr < 4; rr++) begin
        t[4*c+rr] = SBOX[get_byte(s, 4*((c+rr)%4)+rr)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      for (int rr = 0; rr < 4; rr++) a[rr] = t[4*c+rr];
      for (int rr = 0; rr < 4; rr++) begin
        if (!last) begin
          r[127-8*(4*c+rr) -: 8] = xtime(a[rr]) ^ xtime(a[(rr+1)%4]) ^ a[(rr+1)%4]
                                   ^ a[(rr+2)%4] ^ a[(rr+3)%4] ^ get_byte(k, 4*c+rr);
        end else begin
          r[127-8*(4*c+rr) -: 8] = a[rr] ^ get_byte(k, 4*c+rr);
        end
      end
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/aes_stream_if.sv
interface aes_stream_if;
  logic valid;
  logic ready;
  logic [63:0] data_high;
  logic [63:0] data_low;
  modport source (output valid, data_high, data_low, input ready);
  modport sink (input valid, data_high, data_low, output ready);
endinterface

// File: hw/rtl/aes_cfg_if.sv
interface aes_cfg_if;
  logic valid;
  logic ready;
  logic [0:0] index;
  logic [63:0] wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

// File: hw/rtl/aes_round_cell.sv
// One round of the cipher and of the key schedule; data and key move on together.
module aes_round_cell (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  input  logic valid_i,
  input  aes_pkg::blk_t state_i,
  input  aes_pkg::blk_t key_i,
  input  aes_pkg::byte_t rcon_i,
  input  logic last_i,
  output logic valid_o,
  output aes_pkg::blk_t state_o,
  output aes_pkg::blk_t key_o
);
  import aes_pkg::*;

  logic valid_q;
  blk_t state_q, key_q, key_d;

  assign key_d = next_key(key_i, rcon_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      state_q <= round_fn(state_i, key_d, last_i);
      key_q <= key_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
  assign key_o = key_q;
endmodule

// File: hw/rtl/aes128_block_encrypt.sv
// AES-128 encryption, one 128-bit block per cycle unless stalled. A request goes
// through an input register holding the initial AddRoundKey and then ten round
// cells, each carrying its block and its round key; the result appears at the
// output of the last cell. The key registers are written through cfg and are
// expanded on the fly alongside each block. The chain stalls as a whole when
// the output is valid and not taken.
`include "aes128_block_encrypt_defines.svh"
module aes128_block_encrypt (
  input logic clk_i,
  input logic rst_ni,
  aes_stream_if.sink in_i,
  aes_stream_if.source out_o,
  aes_cfg_if.sink cfg_i
);
  import aes_pkg::*;

  logic [HalfW-1:0] key_high_q, key_low_q;
  logic adv;
  logic v [NumRounds+1];
  blk_t s [NumRounds+1];
  blk_t k [NumRounds+1];
  logic v0_q;
  blk_t s0_q, k0_q;
  stage_ctl_t ctl;

  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        RegKeyHigh: key_high_q <= cfg_i.wdata;
        RegKeyLow: key_low_q <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  assign ctl.valid = v[NumRounds];
  assign ctl.stall = ctl.valid && !out_o.ready;
  assign adv = !ctl.stall;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_q <= {in_i.data_high, in_i.data_low} ^ {key_high_q, key_low_q};
      k0_q <= {key_high_q, key_low_q};
    end
  end

  assign v[0] = v0_q;
  assign s[0] = s0_q;
  assign k[0] = k0_q;

  for (genvar r = 0; r < NumRounds; r++) begin : g_cell
    aes_round_cell u_cell (
      .clk_i(clk_i), .rst_ni(rst_ni), .adv_i(adv),
      .valid_i(v[r]), .state_i(s[r]), .key_i(k[r]), .rcon_i(RCON[r]),
      .last_i(r == NumRounds-1),
      .valid_o(v[r+1]), .state_o(s[r+1]), .key_o(k[r+1])
    );
  end

  assign out_o.valid = ctl.valid;
  assign out_o.data_high = s[NumRounds][127:64];
  assign out_o.data_low = s[NumRounds][63:0];

  `AES_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_o.valid && !out_o.ready,
    out_o.valid && $stable(out_o.data_high), "result changed under stall")
  `AES_ASSERT(a_rdy, clk_i, rst_ni, in_i.ready == !(out_o.valid && !out_o.ready),
    "input ready does not follow output stall")
  `AES_ASSERT_NEXT(a_first, clk_i, rst_ni, in_i.valid && in_i.ready, v0_q,
    "accepted request lost at entry")
endmodule
